### design/thermo_pkg.sv
// Shared constants, stage structs and segment lookup for the thermometer display driver.
package thermo_pkg;

    localparam logic [15:0]        READING_LIMIT  = 16'd64000;
    localparam logic signed [11:0] CELSIUS_OFFSET = 12'sd500;
    localparam logic signed [11:0] FAHR_OFFSET    = 12'sd320;

    // floor(m * 9 / 5) = (m * FAHR_RECIP) >> FAHR_SHIFT for m < 4096
    localparam logic [13:0] FAHR_RECIP = 14'd14746;
    localparam int          FAHR_SHIFT = 13;

    // Reciprocals for digit extraction, exact for magnitudes below 2048
    localparam logic [10:0] RECIP_TEN      = 11'd1639;  // >> 14
    localparam logic [10:0] RECIP_HUNDRED  = 11'd1311;  // >> 17
    localparam logic [10:0] RECIP_THOUSAND = 11'd1049;  // >> 20

    localparam logic [6:0] MINUS_SEG       = 7'b0000001;
    localparam logic [6:0] BLANK_SEG       = 7'b0000000;
    localparam logic [1:0] UNIT_CELSIUS    = 2'b01;
    localparam logic [1:0] UNIT_FAHRENHEIT = 2'b10;

    typedef struct packed {
        logic               oor;
        logic               fahr;
        logic               neg;
        logic signed [11:0] cel_tenths;
        logic [10:0]        fahr_mag;
    } scale_t;

    typedef struct packed {
        logic               oor;
        logic               fahr;
        logic               neg;
        logic signed [11:0] tenths;
        logic [10:0]        mag;
        logic [7:0]         quot_ten;
        logic [4:0]         quot_hundred;
        logic [1:0]         quot_thousand;
    } digit_t;

    function automatic logic [6:0] digit_seg(input logic [3:0] digit);
        logic [6:0] seg;
        begin
            case (digit)
                4'd0:    seg = 7'b1111110;
                4'd1:    seg = 7'b0001100;
                4'd2:    seg = 7'b0110111;
                4'd3:    seg = 7'b0011111;
                4'd4:    seg = 7'b1001101;
                4'd5:    seg = 7'b1011011;
                4'd6:    seg = 7'b1111011;
                4'd7:    seg = 7'b0001110;
                4'd8:    seg = 7'b1111111;
                4'd9:    seg = 7'b1011111;
                default: seg = BLANK_SEG;
            endcase
            return seg;
        end
    endfunction

endpackage

### design/thermo_scale.sv
// Raw count to Celsius tenths, plus the scaled magnitude for Fahrenheit.
module thermo_scale (
    input  logic [15:0]      sensor_reading,
    input  logic             fahr,
    output thermo_pkg::scale_t scale
);
    import thermo_pkg::*;

    logic [10:0]        cel_count;
    logic signed [11:0] cel_tenths;
    logic signed [11:0] cel_negated;
    logic [9:0]         cel_mag;
    logic [23:0]        fahr_prod;

    // Round up when the remainder exceeds 31, i.e. bit 5 of the count is set
    assign cel_count   = {1'b0, sensor_reading[15:6]} + {10'd0, sensor_reading[5]};
    assign cel_tenths  = $signed({1'b0, cel_count}) - CELSIUS_OFFSET;
    assign cel_negated = -cel_tenths;
    assign cel_mag     = cel_tenths[11] ? cel_negated[9:0] : cel_tenths[9:0];
    assign fahr_prod   = {14'd0, cel_mag} * {10'd0, FAHR_RECIP};

    always_comb
    begin
        scale.oor        = (sensor_reading > READING_LIMIT);
        scale.fahr       = fahr;
        scale.neg        = cel_tenths[11];
        scale.cel_tenths = cel_tenths;
        scale.fahr_mag   = fahr_prod[23:FAHR_SHIFT];
    end

endmodule

### design/thermo_digits.sv
// Final temperature selection and decimal quotients of its magnitude.
module thermo_digits (
    input  thermo_pkg::scale_t scale,
    output thermo_pkg::digit_t digits
);
    import thermo_pkg::*;

    logic signed [11:0] fahr_abs;
    logic signed [11:0] fahr_signed;
    logic signed [11:0] tenths;
    logic signed [11:0] tenths_negated;
    logic [10:0]        mag;
    logic [21:0]        prod_ten;
    logic [21:0]        prod_hundred;
    logic [21:0]        prod_thousand;

    // Truncate toward zero: scale the magnitude, then restore the sign
    assign fahr_abs       = $signed({1'b0, scale.fahr_mag});
    assign fahr_signed    = scale.neg ? -fahr_abs : fahr_abs;
    assign tenths         = scale.fahr ? (fahr_signed + FAHR_OFFSET) : scale.cel_tenths;
    assign tenths_negated = -tenths;
    assign mag            = tenths[11] ? tenths_negated[10:0] : tenths[10:0];

    assign prod_ten      = {11'd0, mag} * {11'd0, RECIP_TEN};
    assign prod_hundred  = {11'd0, mag} * {11'd0, RECIP_HUNDRED};
    assign prod_thousand = {11'd0, mag} * {11'd0, RECIP_THOUSAND};

    always_comb
    begin
        digits.oor           = scale.oor;
        digits.fahr          = scale.fahr;
        digits.neg           = tenths[11];
        digits.tenths        = tenths;
        digits.mag           = mag;
        digits.quot_ten      = prod_ten[21:14];
        digits.quot_hundred  = prod_hundred[21:17];
        digits.quot_thousand = prod_thousand[21:20];
    end

endmodule

### design/thermo_encode.sv
// Digit remainders, leading-zero blanking, sign placement and unit code.
module thermo_encode (
    input  thermo_pkg::digit_t digits,
    output logic               out_of_range,
    output logic               display_write,
    output logic [29:0]        display_word,
    output logic signed [11:0] tenths_value
);
    import thermo_pkg::*;

    logic [10:0] ten_times_q1;
    logic [7:0]  ten_times_q2;
    logic [4:0]  ten_times_q3;
    logic [10:0] rem0;
    logic [7:0]  rem1;
    logic [4:0]  rem2;
    logic [3:0]  d0;
    logic [3:0]  d1;
    logic [3:0]  d2;
    logic [3:0]  d3;
    logic [6:0]  seg_tens;
    logic [6:0]  seg_hundreds;
    logic [1:0]  unit;

    assign ten_times_q1 = {digits.quot_ten, 3'b000} + {2'b00, digits.quot_ten, 1'b0};
    assign ten_times_q2 = {digits.quot_hundred, 3'b000} + {2'b00, digits.quot_hundred, 1'b0};
    assign ten_times_q3 = {digits.quot_thousand, 3'b000} + {2'b00, digits.quot_thousand, 1'b0};
    assign rem0 = digits.mag - ten_times_q1;
    assign rem1 = digits.quot_ten - ten_times_q2;
    assign rem2 = digits.quot_hundred - ten_times_q3;
    assign d0   = rem0[3:0];
    assign d1   = rem1[3:0];
    assign d2   = rem2[3:0];
    assign d3   = {2'b00, digits.quot_thousand};
    assign unit = digits.fahr ? UNIT_FAHRENHEIT : UNIT_CELSIUS;

    always_comb
    begin
        seg_tens     = BLANK_SEG;
        seg_hundreds = BLANK_SEG;
        if (digits.neg)
        begin
            // Minus sits just left of the highest digit shown
            if (d3 == 4'd0 && d2 == 4'd0)
            begin
                seg_tens = MINUS_SEG;
            end
            else if (d3 == 4'd0)
            begin
                seg_tens     = digit_seg(d2);
                seg_hundreds = MINUS_SEG;
            end
        end
        else
        begin
            if (d3 != 4'd0)
            begin
                seg_hundreds = digit_seg(d3);
            end
            if (d3 != 4'd0 || d2 != 4'd0)
            begin
                seg_tens = digit_seg(d2);
            end
        end
    end

    always_comb
    begin
        out_of_range = digits.oor;
        if (digits.oor)
        begin
            display_write = 1'b0;
            display_word  = 30'd0;
            tenths_value  = 12'sd0;
        end
        else
        begin
            display_write = 1'b1;
            display_word  = {unit, seg_hundreds, seg_tens, digit_seg(d1), digit_seg(d0)};
            tenths_value  = digits.tenths;
        end
    end

endmodule

### design/sensor_to_seven_segment_thermometer_top.sv
// Top level: sensor count to seven-segment thermometer display word.
//
//  Channel   Handshake            Payload
//  --------  -------------------  ---------------------------------------------------
//  input     start, busy          sensor_reading[15:0]
//  config    cfg_we               cfg_wdata (show_fahrenheit)
//  result    done (one cycle)     out_of_range, display_write, display_word[29:0],
//                                 tenths_value[11:0]
//
//  One transaction enters per cycle; busy stays low. The path has four register
//  stages (input, scaled value, decimal quotients, result), and done is registered
//  alongside the result. Every transaction gives exactly one result.
//  rst_n clears the valid pipeline and the unit register (Celsius).
//  The receiver cannot stall: each result is shown for one cycle only.
module sensor_to_seven_segment_thermometer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        sensor_reading,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output logic               done,
    output logic               out_of_range,
    output logic               display_write,
    output logic [29:0]        display_word,
    output logic signed [11:0] tenths_value
);
    import thermo_pkg::*;

    logic               fahr_reg;
    logic               in_valid_reg;
    logic [15:0]        reading_reg;
    logic               in_fahr_reg;
    logic               scale_valid_reg;
    scale_t             scale_next;
    scale_t             scale_reg;
    logic               digit_valid_reg;
    digit_t             digit_next;
    digit_t             digit_reg;
    logic               done_reg;
    logic               oor_next;
    logic               write_next;
    logic [29:0]        word_next;
    logic signed [11:0] tenths_next;
    logic               oor_reg;
    logic               write_reg;
    logic [29:0]        word_reg;
    logic signed [11:0] tenths_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fahr_reg        <= 1'b0;
            in_valid_reg    <= 1'b0;
            scale_valid_reg <= 1'b0;
            digit_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fahr_reg <= cfg_wdata;
            end
            in_valid_reg    <= start && !busy;
            scale_valid_reg <= in_valid_reg;
            digit_valid_reg <= scale_valid_reg;
            done_reg        <= digit_valid_reg;
        end
    end

    // Payload stages advance every cycle; the valid pipeline marks live data
    always_ff @(posedge clk)
    begin
        reading_reg <= sensor_reading;
        in_fahr_reg <= fahr_reg;
        scale_reg   <= scale_next;
        digit_reg   <= digit_next;
        oor_reg     <= oor_next;
        write_reg   <= write_next;
        word_reg    <= word_next;
        tenths_reg  <= tenths_next;
    end

    thermo_scale u_scale (
        .sensor_reading (reading_reg),
        .fahr           (in_fahr_reg),
        .scale          (scale_next)
    );

    thermo_digits u_digits (
        .scale  (scale_reg),
        .digits (digit_next)
    );

    thermo_encode u_encode (
        .digits        (digit_reg),
        .out_of_range  (oor_next),
        .display_write (write_next),
        .display_word  (word_next),
        .tenths_value  (tenths_next)
    );

    assign done          = done_reg;
    assign out_of_range  = oor_reg;
    assign display_write = write_reg;
    assign display_word  = word_reg;
    assign tenths_value  = tenths_reg;

endmodule
